@@ hw/rtl/ecgr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecgr_pkg: shared types and constants for the R-peak detector
// Register indexes, defaults and field widths.
// ----------------------------------------------------------------------------
package ecgr_pkg;
  localparam int WindowLenDef  = 54;
  localparam int SampleBitsDef = 16;
  localparam int ValW = 36;
  localparam int AgeW = 8;
  localparam int DistW = 10;
  localparam int LrW = 16;

  typedef enum logic [1:0] {
    REG_LEVEL_GAIN    = 2'd0,
    REG_MIN_HEIGHT    = 2'd1,
    REG_MIN_DISTANCE  = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQUARE, ST_DIVIDE, ST_DECIDE, ST_BLEND_SIG, ST_BLEND_NOISE, ST_THRESH, ST_OUT
  } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/ecgr_blend.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecgr_blend: serial level update
// Computes (lr*x + (65536-lr)*level) >> 16, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ecgr_blend (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [15:0]           lr,
  input  wire logic [ecgr_pkg::ValW-1:0] x,
  input  wire logic [ecgr_pkg::ValW-1:0] level,
  output logic                       busy,
  output logic [ecgr_pkg::ValW-1:0]  result
);
  import ecgr_pkg::*;

  logic [16:0] wa;
  logic [16:0] wb;
  logic [ValW-1:0] xa;
  logic [ValW-1:0] xb;
  logic [ValW+17:0] acc;
  logic [4:0] cnt;

  // Shift-add over 17 weight bits, LSB first; accumulator shifts right
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      wa   <= {1'b0, lr};
      wb   <= 17'h10000 - {1'b0, lr};
      xa   <= x;
      xb   <= level;
      acc  <= '0;
    end else if (busy) begin
      acc <= ({1'b0, acc[ValW+17:1]} +
              ({{18{1'b0}}, (wa[0] ? xa : '0)} << 17) +
              ({{18{1'b0}}, (wb[0] ? xb : '0)} << 17));
      wa  <= wa >> 1;
      wb  <= wb >> 1;
      cnt <= cnt + 5'd1;
      if (cnt == 5'd16) busy <= 1'b0;
    end
  end

  assign result = acc[ValW+16:17];
endmodule
`default_nettype wire

@@ hw/rtl/ecg_r_peak_detector_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_r_peak_detector_core: Pan-Tompkins style R-peak detector
// Derivative, squared moving-window integral, adaptive threshold.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// sample    in   sample_valid/sample_ready sample
// result    out  result_valid/result_ready integrated threshold peak_found ...
// cfg       in   cfg_valid/cfg_ready       cfg_index cfg_data
// A sample passes from its transfer to result_valid through a 2-bit serial
// square, a restoring divide by the window length, a decide state, two serial
// blends (each skipped when not needed), a threshold and an output state.
// Reset clears control and the window store valid bits.
// A stalled result holds in the output register; the next sample is taken
// and processed, then waits in the output stage until the register is free.
// ----------------------------------------------------------------------------
module ecg_r_peak_detector_core #(
  parameter int WINDOW_LEN  = ecgr_pkg::WindowLenDef,
  parameter int SAMPLE_BITS = ecgr_pkg::SampleBitsDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         sample_valid,
  output logic                              sample_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic [ecgr_pkg::ValW-1:0]         integrated,
  output logic [ecgr_pkg::ValW-1:0]         threshold,
  output logic                              peak_found,
  output logic [ecgr_pkg::AgeW-1:0]         peak_age,
  output logic [ecgr_pkg::ValW-1:0]         peak_height,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [ecgr_pkg::ValW-1:0]    cfg_data
);
  import ecgr_pkg::*;

  localparam int DW   = SAMPLE_BITS + 3;       // derivative width
  localparam int MW   = DW - 1;                // magnitude width
  localparam int SQW  = 2 * MW;                // full square width
  localparam int SLW  = $clog2(WINDOW_LEN);
  localparam int SUMW = ValW + 8;              // window sum width
  localparam int DCW  = $clog2(SUMW + 1);
  localparam logic [ValW-1:0] MAX36 = {ValW{1'b1}};

  // Configuration
  logic [LrW-1:0]   lvl_gain;
  logic [ValW-1:0]  height_floor;
  logic [DistW-1:0] refract_dist;

  // State
  logic signed [SAMPLE_BITS-1:0] dl0, dl1, dl2, dl3;
  logic [ValW-1:0] wstore [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] wvalid;
  logic [SLW-1:0] slot;
  logic [SUMW-1:0] wsum;
  logic [ValW-1:0] best_height, signal_level, noise_level, low_threshold;
  logic cand_valid;
  logic [AgeW-1:0] cand_age;
  logic [DistW-1:0] since_last;

  // Work registers
  state_t state, state_next;
  logic [SQW-1:0] mcand;
  logic [MW-1:0] mplier;
  logic [SQW-1:0] sq_acc;
  logic [DCW-1:0] cnt;
  logic [SUMW-1:0] dquo;
  logic [SUMW-1:0] drem;
  logic [ValW-1:0] old_thr, old_entry;
  logic found;
  logic do_noise;
  logic [AgeW-1:0] pk_age;
  logic [ValW-1:0] pk_height;

  logic blend_start, blend_busy;
  logic [ValW-1:0] bx, blev, bres;

  ecgr_blend u_blend (
    .clk(clk), .rst(rst), .start(blend_start), .lr(lvl_gain),
    .x(bx), .level(blev), .busy(blend_busy), .result(bres)
  );

  // Derivative of the new sample and its magnitude
  logic signed [DW-1:0] deriv;
  logic [MW-1:0] dmag;
  assign deriv = (DW'(sample) <<< 1) + DW'(dl0) - DW'(dl2) - (DW'(dl3) <<< 1);
  assign dmag  = deriv[DW-1] ? MW'(-deriv) : MW'(deriv);

  // Saturated square
  logic [ValW-1:0] sq;
  always_comb begin
    if (SQW > ValW && (sq_acc >> ValW) != '0) sq = MAX36;
    else sq = ValW'(sq_acc);
  end

  // Saturated integral from the final quotient
  logic [ValW-1:0] integ;
  assign integ = ((dquo >> ValW) != '0) ? MAX36 : dquo[ValW-1:0];

  // Threshold from the current levels
  logic [ValW+2:0] thr_sum;
  logic [ValW-1:0] thr_next;
  assign thr_sum  = (ValW+3)'({noise_level, 1'b0}) + (ValW+3)'(noise_level) +
                    (ValW+3)'(signal_level);
  assign thr_next = thr_sum[ValW+2:3];

  logic out_free;
  assign out_free = !result_valid || result_ready;

  assign sample_ready = (state == ST_IDLE);
  assign cfg_ready    = (state == ST_IDLE) && !result_valid;

  // Restoring division step
  logic [SUMW:0] dtrial;
  assign dtrial = {drem[SUMW-1:0], dquo[SUMW-1]} - (SUMW+1)'(WINDOW_LEN);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (sample_valid && sample_ready) state_next = ST_SQUARE;
      ST_SQUARE:      if (mplier == '0) state_next = ST_DIVIDE;
      ST_DIVIDE:      if (cnt == DCW'(SUMW - 1)) state_next = ST_DECIDE;
      ST_DECIDE:      state_next = ST_BLEND_SIG;
      ST_BLEND_SIG:   if (!blend_busy) state_next = ST_BLEND_NOISE;
      ST_BLEND_NOISE: if (!blend_busy) state_next = ST_THRESH;
      ST_THRESH:      if (!blend_busy) state_next = ST_OUT;
      ST_OUT:         if (out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // Decision logic for one sample
  logic [DistW-1:0] since_inc;
  logic [AgeW-1:0] age_inc;
  logic take, confirm, accept_pk;
  always_comb begin
    since_inc = (since_last == '1) ? since_last : since_last + 1'b1;
    age_inc   = (cand_valid && cand_age != '1) ? cand_age + 1'b1 : cand_age;
    take      = integ > old_thr && integ > best_height && since_inc >= refract_dist;
    confirm   = !take && cand_valid &&
                (integ < old_thr || 32'(age_inc) > 32'(WINDOW_LEN) || age_inc == '1);
    accept_pk = confirm && best_height > height_floor;
  end

  // Blend unit control
  always_comb begin
    blend_start = 1'b0;
    bx   = integ;
    blev = noise_level;
    unique case (state)
      ST_DECIDE: begin
        blend_start = accept_pk;
        bx   = best_height;
        blev = signal_level;
      end
      ST_BLEND_SIG: blend_start = !blend_busy && do_noise;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lvl_gain <= LrW'(8192);
      height_floor <= ValW'(1);
      refract_dist <= DistW'(200);
      dl0 <= '0; dl1 <= '0; dl2 <= '0; dl3 <= '0;
      wvalid <= '0;
      slot <= '0;
      wsum <= '0;
      best_height <= '0;
      cand_valid <= 1'b0;
      cand_age <= '0;
      since_last <= '0;
      signal_level <= '0;
      noise_level <= '0;
      low_threshold <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LEVEL_GAIN:   lvl_gain <= cfg_data[LrW-1:0];
          REG_MIN_HEIGHT:   height_floor <= cfg_data;
          REG_MIN_DISTANCE: refract_dist <= cfg_data[DistW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (sample_valid && sample_ready) begin
          mcand  <= SQW'(dmag);
          mplier <= dmag;
          sq_acc <= '0;
          dl0 <= sample; dl1 <= dl0; dl2 <= dl1; dl3 <= dl2;
          old_entry <= wvalid[slot] ? wstore[slot] : '0;
          old_thr <= low_threshold;
        end
        ST_SQUARE: begin
          // two multiplier bits per cycle, multiplicand shifts left
          if (mplier != '0) begin
            sq_acc <= sq_acc + (mplier[0] ? mcand : '0) +
                      (mplier[1] ? {mcand[SQW-2:0], 1'b0} : '0);
            mcand  <= mcand << 2;
            mplier <= mplier >> 2;
          end else begin
            wstore[slot] <= sq;
            wvalid[slot] <= 1'b1;
            slot <= (32'(slot) + 1 >= WINDOW_LEN) ? '0 : slot + 1'b1;
            dquo <= wsum - SUMW'(old_entry) + SUMW'(sq);
            wsum <= wsum - SUMW'(old_entry) + SUMW'(sq);
            drem <= '0;
            cnt  <= '0;
          end
        end
        ST_DIVIDE: begin
          if (!dtrial[SUMW]) begin
            drem <= dtrial[SUMW-1:0];
            dquo <= {dquo[SUMW-2:0], 1'b1};
          end else begin
            drem <= {drem[SUMW-2:0], dquo[SUMW-1]};
            dquo <= {dquo[SUMW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        default: ;
      endcase
      if (state == ST_DECIDE) begin
        found <= accept_pk;
        pk_age <= accept_pk ? age_inc : '0;
        pk_height <= accept_pk ? best_height : '0;
        since_last <= accept_pk ? DistW'(age_inc) + 1'b1 : since_inc;
        if (take) begin
          best_height <= integ;
          cand_valid <= 1'b1;
          cand_age <= '0;
        end else if (confirm) begin
          best_height <= '0;
          cand_valid <= 1'b0;
          cand_age <= '0;
        end else begin
          cand_age <= age_inc;
        end
        do_noise <= integ <= old_thr;
      end
      if (state == ST_BLEND_SIG && !blend_busy && found) signal_level <= bres;
      if (state == ST_THRESH && !blend_busy) begin
        if (do_noise) noise_level <= bres;
      end
      // Output register: load when free or drained this cycle
      if (state == ST_OUT && out_free) begin
        low_threshold <= thr_next;
        integrated <= integ;
        threshold <= thr_next;
        peak_found <= found;
        peak_age <= pk_age;
        peak_height <= pk_height;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(integrated))
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    peak_found && result_valid |-> peak_height > height_floor)
    else $error("peak below minimum height");
  assert property (@(posedge clk) disable iff (rst)
    32'(slot) < WINDOW_LEN)
    else $error("window slot out of range");
endmodule
`default_nettype wire
